### hdl/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared constants, codes and CRC helpers for the Modbus RTU response checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mrc_pkg;

    localparam int MAX_FRAME_DEF = 256;

    // expected frame length is at most 5 + 2 * 65535
    localparam int LEN_W = 18;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // configuration register indexes
    localparam logic REG_REQ_FUNCTION = 1'b0;
    localparam logic REG_REQ_QUANTITY = 1'b1;

    localparam logic [7:0] REQ_FUNCTION_RST = 8'h03;

    // function codes
    localparam logic [7:0] FC_READ_COILS        = 8'h01;
    localparam logic [7:0] FC_READ_DISCRETE     = 8'h02;
    localparam logic [7:0] FC_READ_HOLDING      = 8'h03;
    localparam logic [7:0] FC_READ_INPUT        = 8'h04;
    localparam logic [7:0] FC_READ_EXC_STATUS   = 8'h07;
    localparam logic [7:0] FC_WRITE_MULTI_COILS = 8'h0F;
    localparam logic [7:0] FC_WRITE_MULTI_REGS  = 8'h10;
    localparam logic [7:0] FC_REPORT_ID         = 8'h11;
    localparam logic [7:0] FC_WRITE_READ_REGS   = 8'h17;

    // result kinds
    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // frame status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_LEN_ERR   = 3'd1;
    localparam logic [2:0] ST_FUNC_ERR  = 3'd2;
    localparam logic [2:0] ST_COUNT_ERR = 3'd3;
    localparam logic [2:0] ST_EXCEPTION = 3'd4;

    // one entry of the byte-wise CRC-16/MODBUS table
    function automatic logic [15:0] crc_tbl(input logic [7:0] idx);
        logic [15:0] c;
        c = {8'h00, idx};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
        return {8'h00, c[15:8]} ^ crc_tbl(c[7:0] ^ b);
    endfunction

    function automatic logic is_reg_read(input logic [7:0] fc);
        return fc inside {FC_READ_HOLDING, FC_READ_INPUT, FC_WRITE_READ_REGS};
    endfunction

endpackage

`default_nettype wire

### hdl/mrc_ifs.sv
// ----------------------------------------------------------------------------
// mrc_ifs
// Valid/ready channels for received bytes and for checker results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mrc_res_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [15:0] word_value;
    logic [15:0] value_count;
    logic [2:0]  status;
    logic [7:0]  exc_code;
    logic        crc_ok;

    modport source (output valid, output result_kind, output word_value,
                    output value_count, output status, output exc_code,
                    output crc_ok, input ready);
    modport sink   (input valid, input result_kind, input word_value,
                    input value_count, input status, input exc_code,
                    input crc_ok, output ready);
endinterface

`default_nettype wire

### hdl/modbus_rtu_response_checker.sv
// A result appears in the output register in the cycle after its byte
// is accepted. One byte per cycle; a new byte is taken while the
// previous result waits, as long as the output register can be emptied.
// The CRC table step, the length compare and the count compare all sit
// between the frame state and the output register.
// Reset (synchronous, active low) restores request registers and frame state.
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker
// Checks a Modbus RTU response byte stream: CRC-16/MODBUS, header fields,
// expected length and value count; emits register words and a frame status.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_response_checker #(
    parameter int MAX_FRAME = mrc_pkg::MAX_FRAME_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [15:0] i_cfg_wdata,
    mrc_rx_if.sink      i_rx,
    mrc_res_if.source   o_res
);

    localparam int IDX_W = $clog2(MAX_FRAME + 1);
    localparam int LEN_W = mrc_pkg::LEN_W;

    logic [7:0]       r_req_fn,  n_req_fn;
    logic [15:0]      r_req_qty, n_req_qty;
    logic [15:0]      r_crc,     n_crc;
    logic [7:0]       r_tail0,   n_tail0;
    logic [7:0]       r_tail1,   n_tail1;
    logic [IDX_W-1:0] r_idx,     n_idx;
    logic [7:0]       r_rsp_fn,  n_rsp_fn;
    logic [7:0]       r_rsp_cnt, n_rsp_cnt;
    logic [15:0]      r_rsp_qty, n_rsp_qty;
    logic [7:0]       r_whi,     n_whi;

    logic             r_out_valid, n_out_valid;
    logic             r_kind,      n_kind;
    logic [15:0]      r_word,      n_word;
    logic [15:0]      r_count,     n_count;
    logic [2:0]       r_status,    n_status;
    logic [7:0]       r_exc,       n_exc;
    logic             r_crc_ok,    n_crc_ok;

    logic             acc;
    logic [15:0]      crc_fed;
    logic [13:0]      bytes_for_bits;
    logic [LEN_W-1:0] frame_len;
    logic [LEN_W-1:0] expect_len;
    logic             len_free;
    logic [15:0]      want, got;
    logic [2:0]       st;
    logic [15:0]      cnt;
    logic [7:0]       exc;

    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign acc        = i_rx.valid && i_rx.ready;

    assign o_res.valid       = r_out_valid;
    assign o_res.result_kind = r_kind;
    assign o_res.word_value  = r_word;
    assign o_res.value_count = r_count;
    assign o_res.status      = r_status;
    assign o_res.exc_code    = r_exc;
    assign o_res.crc_ok      = r_crc_ok;

    assign crc_fed = (r_idx >= IDX_W'(2)) ? mrc_pkg::crc_feed(r_crc, r_tail0) : r_crc;

    assign bytes_for_bits = {1'b0, r_req_qty[15:3]} + {13'd0, |r_req_qty[2:0]};

    // frame length counts the current byte, held at the frame maximum
    assign frame_len = (r_idx == IDX_W'(MAX_FRAME)) ? LEN_W'(MAX_FRAME)
                                                    : LEN_W'(r_idx) + LEN_W'(1);

    always_comb begin
        expect_len = LEN_W'(8);
        len_free   = 1'b0;
        case (r_req_fn)
            mrc_pkg::FC_READ_COILS,
            mrc_pkg::FC_READ_DISCRETE:   expect_len = LEN_W'(bytes_for_bits) + LEN_W'(5);
            mrc_pkg::FC_READ_HOLDING,
            mrc_pkg::FC_READ_INPUT,
            mrc_pkg::FC_WRITE_READ_REGS: expect_len = LEN_W'({r_req_qty, 1'b0}) + LEN_W'(5);
            mrc_pkg::FC_READ_EXC_STATUS: expect_len = LEN_W'(6);
            mrc_pkg::FC_REPORT_ID:       len_free   = 1'b1;
            default:                     expect_len = LEN_W'(8);
        endcase
    end

    // value count check; only meaningful when the response function matches
    always_comb begin
        case (r_rsp_fn)
            mrc_pkg::FC_READ_COILS,
            mrc_pkg::FC_READ_DISCRETE: begin
                want = {2'b00, bytes_for_bits};
                got  = {8'h00, r_rsp_cnt};
            end
            mrc_pkg::FC_READ_HOLDING,
            mrc_pkg::FC_READ_INPUT,
            mrc_pkg::FC_WRITE_READ_REGS: begin
                want = r_req_qty;
                got  = {9'd0, r_rsp_cnt[7:1]};
            end
            mrc_pkg::FC_WRITE_MULTI_COILS,
            mrc_pkg::FC_WRITE_MULTI_REGS: begin
                want = r_req_qty;
                got  = r_rsp_qty;
            end
            mrc_pkg::FC_REPORT_ID: begin
                want = {8'h00, r_rsp_cnt};
                got  = {8'h00, r_rsp_cnt};
            end
            default: begin
                want = 16'd1;
                got  = 16'd1;
            end
        endcase
    end

    always_comb begin
        st  = mrc_pkg::ST_LEN_ERR;
        cnt = 16'd0;
        exc = 8'h00;
        if (len_free || (frame_len == expect_len)) begin
            if (r_rsp_fn != r_req_fn) begin
                st = mrc_pkg::ST_FUNC_ERR;
            end else if (want == got) begin
                st  = mrc_pkg::ST_OK;
                cnt = got;
            end else begin
                st = mrc_pkg::ST_COUNT_ERR;
            end
        end else if ((frame_len == LEN_W'(5)) && r_rsp_fn[7] && !r_req_fn[7] &&
                     (r_req_fn[6:0] == r_rsp_fn[6:0])) begin
            st  = mrc_pkg::ST_EXCEPTION;
            exc = r_rsp_cnt;
        end
    end

    always_comb begin
        n_req_fn    = r_req_fn;
        n_req_qty   = r_req_qty;
        n_crc       = r_crc;
        n_tail0     = r_tail0;
        n_tail1     = r_tail1;
        n_idx       = r_idx;
        n_rsp_fn    = r_rsp_fn;
        n_rsp_cnt   = r_rsp_cnt;
        n_rsp_qty   = r_rsp_qty;
        n_whi       = r_whi;
        n_out_valid = r_out_valid && !o_res.ready;
        n_kind      = r_kind;
        n_word      = r_word;
        n_count     = r_count;
        n_status    = r_status;
        n_exc       = r_exc;
        n_crc_ok    = r_crc_ok;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                mrc_pkg::REG_REQ_FUNCTION: n_req_fn  = i_cfg_wdata[7:0];
                mrc_pkg::REG_REQ_QUANTITY: n_req_qty = i_cfg_wdata;
                default:                   n_req_fn  = r_req_fn;
            endcase
        end

        if (acc) begin
            if (i_rx.frame_end) begin
                n_out_valid = 1'b1;
                n_kind      = mrc_pkg::KIND_STATUS;
                n_word      = 16'd0;
                n_count     = cnt;
                n_status    = st;
                n_exc       = exc;
                n_crc_ok    = (r_idx != '0) && (crc_fed == {i_rx.rx_byte, r_tail1});
                // drop frame state for the next response
                n_crc       = mrc_pkg::CRC_INIT;
                n_tail0     = 8'h00;
                n_tail1     = 8'h00;
                n_idx       = '0;
                n_rsp_fn    = 8'h00;
                n_rsp_cnt   = 8'h00;
                n_rsp_qty   = 16'd0;
                n_whi       = 8'h00;
            end else begin
                n_out_valid = 1'b0;
                n_crc       = crc_fed;
                if (r_idx == IDX_W'(1)) n_rsp_fn  = i_rx.rx_byte;
                if (r_idx == IDX_W'(2)) n_rsp_cnt = i_rx.rx_byte;
                if (r_idx == IDX_W'(4)) n_rsp_qty = {i_rx.rx_byte, 8'h00};
                if (r_idx == IDX_W'(5)) n_rsp_qty = {r_rsp_qty[15:8], i_rx.rx_byte};

                if ((r_idx < IDX_W'(MAX_FRAME)) && (r_idx >= IDX_W'(3)) &&
                    mrc_pkg::is_reg_read(r_rsp_fn)) begin
                    if (r_idx[0]) begin
                        n_whi = i_rx.rx_byte;
                    end else if (10'(r_idx) <= 10'(r_rsp_cnt) + 10'd2) begin
                        n_out_valid = 1'b1;
                        n_kind      = mrc_pkg::KIND_WORD;
                        n_word      = {r_whi, i_rx.rx_byte};
                        n_count     = 16'd0;
                        n_status    = mrc_pkg::ST_OK;
                        n_exc       = 8'h00;
                        n_crc_ok    = 1'b0;
                    end
                end

                n_tail0 = r_tail1;
                n_tail1 = i_rx.rx_byte;
                if (r_idx < IDX_W'(MAX_FRAME)) n_idx = r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_fn    <= mrc_pkg::REQ_FUNCTION_RST;
            r_req_qty   <= 16'd0;
            r_crc       <= mrc_pkg::CRC_INIT;
            r_tail0     <= 8'h00;
            r_tail1     <= 8'h00;
            r_idx       <= '0;
            r_rsp_fn    <= 8'h00;
            r_rsp_cnt   <= 8'h00;
            r_rsp_qty   <= 16'd0;
            r_whi       <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            r_req_fn    <= n_req_fn;
            r_req_qty   <= n_req_qty;
            r_crc       <= n_crc;
            r_tail0     <= n_tail0;
            r_tail1     <= n_tail1;
            r_idx       <= n_idx;
            r_rsp_fn    <= n_rsp_fn;
            r_rsp_cnt   <= n_rsp_cnt;
            r_rsp_qty   <= n_rsp_qty;
            r_whi       <= n_whi;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_word   <= n_word;
        r_count  <= n_count;
        r_status <= n_status;
        r_exc    <= n_exc;
        r_crc_ok <= n_crc_ok;
    end

endmodule

`default_nettype wire

### hdl/mrc_checker.sv
// ----------------------------------------------------------------------------
// mrc_checker
// Port-level checks for the Modbus RTU response checker, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_rx_valid,
    input wire        i_rx_ready,
    input wire        i_res_valid,
    input wire        i_res_ready,
    input wire        i_res_kind,
    input wire [15:0] i_res_word,
    input wire [15:0] i_res_count,
    input wire [2:0]  i_res_status
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // an empty output register never blocks the byte stream
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid |-> i_rx_ready)
        else $error("input stalled with empty output");

    // a result only follows an accepted byte
    a_result_from_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(i_rx_valid && i_rx_ready))
        else $error("result without accepted beat");

    // hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_kind) && $stable(i_res_word) &&
            $stable(i_res_count) && $stable(i_res_status))
        else $error("stalled result changed");

endmodule

bind modbus_rtu_response_checker mrc_checker u_mrc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rx_valid   (i_rx.valid),
    .i_rx_ready   (i_rx.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_kind   (o_res.result_kind),
    .i_res_word   (o_res.word_value),
    .i_res_count  (o_res.value_count),
    .i_res_status (o_res.status)
);

`default_nettype wire

### tb/sv/modbus_rtu_response_checker_test.sv
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_test
// Self-checking bench for the Modbus RTU response checker. Response frames are
// built with their own CRC, and most of them are well formed for the request
// in force. Some are corrupted, truncated, overlong or pure noise. Every
// accepted byte runs through a cycle-free model of the checker, and each
// result beat is compared field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD     = 20;
    localparam int          FRAME_LIMIT    = mrc_pkg::MAX_FRAME_DEF;
    localparam int          DRAIN_CYCLES   = 6;
    localparam int          HOLDOFF_CYCLES = 300;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          SET_BYTES      = 20;
    localparam logic [7:0]  EXC_FLAG       = 8'h80;

    typedef logic [7:0] t_frame [$];

    typedef struct packed {
        logic        kind;
        logic [15:0] word;
        logic [15:0] count;
        logic [2:0]  status;
        logic [7:0]  exc;
        logic        crc_ok;
    } t_checker_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_wdata;

    mrc_rx_if  rx_chan ();
    mrc_res_if res_chan ();

    modbus_rtu_response_checker u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (rx_chan),
        .o_res       (res_chan)
    );

    // request registers as the block holds them
    logic [7:0]  req_func_copy;
    logic [15:0] req_qty_copy;

    // frame state of the model
    logic [15:0] crc_acc;
    logic [7:0]  prev_bytes [2];
    logic [8:0]  rx_pos;
    logic [7:0]  hdr_func;
    logic [7:0]  hdr_count;
    logic [15:0] hdr_qty;
    logic [7:0]  word_hi;

    t_checker_result pending_frame_results [$];
    t_checker_result head_result;

    int error_count     = 0;
    int bytes_accepted  = 0;
    int tx_gap_pct      = 0;
    int rx_stall_pct    = 0;
    int holdoff_requests = 0;
    int holdoff_served  = 0;
    int holdoff_left    = 0;
    int idle_cycles     = 0;

    logic [7:0] fc_menu [14] = '{mrc_pkg::FC_READ_COILS, mrc_pkg::FC_READ_DISCRETE,
                                 mrc_pkg::FC_READ_HOLDING, mrc_pkg::FC_READ_INPUT,
                                 mrc_pkg::FC_READ_EXC_STATUS, mrc_pkg::FC_WRITE_MULTI_COILS,
                                 mrc_pkg::FC_WRITE_MULTI_REGS, mrc_pkg::FC_REPORT_ID,
                                 mrc_pkg::FC_WRITE_READ_REGS,
                                 8'h05, 8'h06, 8'h00, 8'hFF, 8'h80};

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [15:0] crc16_update(logic [15:0] c, logic [7:0] b);
        c = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ mrc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic bit carries_registers(logic [7:0] fc);
        return fc == mrc_pkg::FC_READ_HOLDING || fc == mrc_pkg::FC_READ_INPUT ||
               fc == mrc_pkg::FC_WRITE_READ_REGS;
    endfunction

    function automatic void clear_frame_state();
        crc_acc       = mrc_pkg::CRC_INIT;
        prev_bytes[0] = 8'h00;
        prev_bytes[1] = 8'h00;
        rx_pos        = '0;
        hdr_func      = 8'h00;
        hdr_count     = 8'h00;
        hdr_qty       = 16'h0000;
        word_hi       = 8'h00;
    endfunction

    // Advance the model by one accepted byte; queue the result it causes.
    function automatic void predict_rx_byte(logic [7:0] b, logic last);
        int unsigned     pos;
        int unsigned     n;
        int unsigned     want_len;
        int unsigned     want_cnt;
        int unsigned     got_cnt;
        int unsigned     coil_bytes;
        bit              no_len;
        t_checker_result r;

        pos = rx_pos;
        r   = '0;
        if (pos >= 2) crc_acc = crc16_update(crc_acc, prev_bytes[0]);

        if (last) begin
            n          = (pos + 1 > FRAME_LIMIT) ? FRAME_LIMIT : pos + 1;
            coil_bytes = (req_qty_copy >> 3) + ((req_qty_copy[2:0] != 3'd0) ? 1 : 0);
            r.kind     = mrc_pkg::KIND_STATUS;
            r.status   = mrc_pkg::ST_LEN_ERR;
            r.crc_ok   = (pos >= 1) && (crc_acc == {b, prev_bytes[1]});
            no_len     = 1'b0;
            case (req_func_copy)
                mrc_pkg::FC_READ_COILS, mrc_pkg::FC_READ_DISCRETE:
                    want_len = 5 + coil_bytes;
                mrc_pkg::FC_READ_HOLDING, mrc_pkg::FC_READ_INPUT,
                mrc_pkg::FC_WRITE_READ_REGS:
                    want_len = 5 + 2 * req_qty_copy;
                mrc_pkg::FC_READ_EXC_STATUS: want_len = 6;
                mrc_pkg::FC_REPORT_ID: begin
                    no_len   = 1'b1;
                    want_len = 0;
                end
                default: want_len = 8;
            endcase

            if (no_len || n == want_len) begin
                if (hdr_func != req_func_copy) begin
                    r.status = mrc_pkg::ST_FUNC_ERR;
                end else begin
                    case (hdr_func)
                        mrc_pkg::FC_READ_COILS, mrc_pkg::FC_READ_DISCRETE: begin
                            want_cnt = coil_bytes;
                            got_cnt  = hdr_count;
                        end
                        mrc_pkg::FC_READ_HOLDING, mrc_pkg::FC_READ_INPUT,
                        mrc_pkg::FC_WRITE_READ_REGS: begin
                            want_cnt = req_qty_copy;
                            got_cnt  = hdr_count >> 1;
                        end
                        mrc_pkg::FC_WRITE_MULTI_COILS, mrc_pkg::FC_WRITE_MULTI_REGS: begin
                            want_cnt = req_qty_copy;
                            got_cnt  = hdr_qty;
                        end
                        mrc_pkg::FC_REPORT_ID: begin
                            want_cnt = hdr_count;
                            got_cnt  = hdr_count;
                        end
                        default: begin
                            want_cnt = 1;
                            got_cnt  = 1;
                        end
                    endcase
                    if (want_cnt == got_cnt) begin
                        r.status = mrc_pkg::ST_OK;
                        r.count  = got_cnt[15:0];
                    end else begin
                        r.status = mrc_pkg::ST_COUNT_ERR;
                    end
                end
            end else if (n == 5 && hdr_func >= EXC_FLAG &&
                         req_func_copy == hdr_func - EXC_FLAG) begin
                r.status = mrc_pkg::ST_EXCEPTION;
                r.exc    = hdr_count;
            end
            pending_frame_results.push_back(r);
            clear_frame_state();
        end else begin
            case (pos)
                1: hdr_func = b;
                2: hdr_count = b;
                4: hdr_qty = {b, 8'h00};
                5: hdr_qty[7:0] = b;
                default: ;
            endcase
            if (pos < FRAME_LIMIT && pos >= 3 && carries_registers(hdr_func)) begin
                if (pos[0]) begin
                    word_hi = b;
                end else if (pos <= hdr_count + 2) begin
                    r.kind = mrc_pkg::KIND_WORD;
                    r.word = {word_hi, b};
                    pending_frame_results.push_back(r);
                end
            end
            prev_bytes[0] = prev_bytes[1];
            prev_bytes[1] = b;
            if (rx_pos < FRAME_LIMIT) rx_pos = rx_pos + 9'd1;
        end
    endfunction

    function automatic t_frame seal_frame(t_frame f);
        logic [15:0] c;
        c = mrc_pkg::CRC_INIT;
        foreach (f[k]) c = crc16_update(c, f[k]);
        f.push_back(c[7:0]);
        f.push_back(c[15:8]);
        return f;
    endfunction

    // Build a well-formed response to function fc; q is the quantity asked
    // for (byte count for report ID).
    function automatic t_frame make_response(logic [7:0] fc, logic [15:0] q);
        t_frame      f;
        int unsigned nbytes;
        f.push_back(8'($urandom_range(1, 247)));
        f.push_back(fc);
        case (fc)
            mrc_pkg::FC_READ_COILS, mrc_pkg::FC_READ_DISCRETE: begin
                nbytes = (q + 7) / 8;
                f.push_back(nbytes[7:0]);
                repeat (nbytes) f.push_back(8'($urandom_range(0, 255)));
            end
            mrc_pkg::FC_READ_HOLDING, mrc_pkg::FC_READ_INPUT,
            mrc_pkg::FC_WRITE_READ_REGS: begin
                nbytes = 2 * q;
                f.push_back(nbytes[7:0]);
                repeat (nbytes) f.push_back(8'($urandom_range(0, 255)));
            end
            mrc_pkg::FC_READ_EXC_STATUS: f.push_back(8'($urandom_range(0, 255)));
            mrc_pkg::FC_WRITE_MULTI_COILS, mrc_pkg::FC_WRITE_MULTI_REGS: begin
                f.push_back(8'($urandom_range(0, 255)));
                f.push_back(8'($urandom_range(0, 255)));
                f.push_back(q[15:8]);
                f.push_back(q[7:0]);
            end
            mrc_pkg::FC_REPORT_ID: begin
                f.push_back(q[7:0]);
                repeat (q[7:0]) f.push_back(8'($urandom_range(0, 255)));
            end
            default: repeat (4) f.push_back(8'($urandom_range(0, 255)));
        endcase
        return seal_frame(f);
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endfunction

    // Offer one byte, with a random gap ahead of it; predict on the beat.
    task automatic send_rx_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            rx_chan.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_chan.valid     <= 1'b1;
        rx_chan.rx_byte   <= b;
        rx_chan.frame_end <= last;
        do @(posedge i_clk); while (!rx_chan.ready);
        predict_rx_byte(b, last);
        bytes_accepted++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input t_frame f);
        for (int k = 0; k < f.size(); k++) begin
            send_rx_byte(f[k], k == f.size() - 1);
        end
    endtask

    task automatic wait_for_idle();
        rx_chan.valid <= 1'b0;
        while (pending_frame_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_request(input logic [7:0] fc, input logic [15:0] qty);
        wait_for_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= mrc_pkg::REG_REQ_FUNCTION;
        i_cfg_wdata <= {8'h00, fc};
        @(negedge i_clk);
        i_cfg_idx   <= mrc_pkg::REG_REQ_QUANTITY;
        i_cfg_wdata <= qty;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        req_func_copy = fc;
        req_qty_copy  = qty;
    endtask

    // Mostly well-formed responses to the request in force; the rest broken.
    task automatic send_random_frame();
        t_frame      f;
        logic [15:0] q;
        int unsigned pos;

        case (req_func_copy)
            mrc_pkg::FC_READ_COILS, mrc_pkg::FC_READ_DISCRETE:
                q = (req_qty_copy <= 160) ? req_qty_copy : 16'($urandom_range(0, 40));
            mrc_pkg::FC_READ_HOLDING, mrc_pkg::FC_READ_INPUT, mrc_pkg::FC_WRITE_READ_REGS:
                q = (req_qty_copy <= 16) ? req_qty_copy : 16'($urandom_range(0, 8));
            mrc_pkg::FC_REPORT_ID: q = 16'($urandom_range(0, 12));
            default: q = req_qty_copy;
        endcase
        f = make_response(req_func_copy, q);

        if ($urandom_range(0, 99) >= 70) begin
            case ($urandom_range(0, 6))
                0: begin
                    pos = $urandom_range(0, f.size() - 1);
                    f[pos] = f[pos] ^ 8'($urandom_range(1, 255));
                end
                1: f = f[0:$-1];
                2: f.push_back(8'($urandom_range(0, 255)));
                3: begin
                    f[1] = 8'($urandom_range(0, 255));
                    f = seal_frame(f[0:$-2]);
                end
                4: begin
                    f.delete();
                    f.push_back(8'($urandom_range(1, 247)));
                    f.push_back(req_func_copy | EXC_FLAG);
                    f.push_back(8'($urandom_range(0, 255)));
                    f = seal_frame(f);
                end
                5: begin
                    f.delete();
                    repeat ($urandom_range(1, 10)) f.push_back(8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 1) == 1) f = seal_frame(f);
                end
                default: begin
                    f[2] = 8'($urandom_range(0, 255));
                    f = seal_frame(f[0:$-2]);
                end
            endcase
        end
        send_frame(f);
    endtask

    task automatic test_directed_frames();
        t_frame f;
        set_request(mrc_pkg::FC_READ_HOLDING, 16'd2);
        // register words at both extremes
        f = {8'h01, mrc_pkg::FC_READ_HOLDING, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00};
        send_frame(seal_frame(f));
        f = {8'h01, mrc_pkg::FC_READ_HOLDING | EXC_FLAG, 8'h02};
        send_frame(seal_frame(f));
        // a lone byte can never carry a CRC
        f = {8'hFF};
        send_frame(f);
        f = {8'h00, 8'h00};
        send_frame(f);
        // frame ends on the low byte of a word: status only
        f = {8'h11, mrc_pkg::FC_READ_HOLDING, 8'h04, 8'hA5, 8'h5A};
        send_frame(f);
    endtask

    task automatic test_request_extremes();
        set_request(8'h00, 16'h0000);
        send_frame(make_response(8'h00, 16'h0000));
        set_request(8'hFF, 16'hFFFF);
        send_frame(make_response(8'hFF, 16'hFFFF));
        set_request(mrc_pkg::FC_WRITE_MULTI_REGS, 16'hFFFF);
        send_frame(make_response(mrc_pkg::FC_WRITE_MULTI_REGS, 16'hFFFF));
        set_request(mrc_pkg::FC_READ_COILS, 16'hFFFF);
        send_frame(make_response(mrc_pkg::FC_READ_COILS, 16'h0000));
        set_request(mrc_pkg::FC_WRITE_READ_REGS, 16'h0000);
        send_frame(make_response(mrc_pkg::FC_WRITE_READ_REGS, 16'h0000));
    endtask

    task automatic test_overlong_frame();
        t_frame f;
        set_request(mrc_pkg::FC_READ_HOLDING, 16'h0000);
        f = {8'h01, mrc_pkg::FC_READ_HOLDING, 8'hFF};
        repeat (FRAME_LIMIT + 34) f.push_back(8'($urandom_range(0, 255)));
        send_frame(seal_frame(f));
    endtask

    task automatic test_output_holdoff();
        set_request(mrc_pkg::FC_READ_INPUT, 16'd30);
        // stall the result side while bytes keep coming
        holdoff_requests++;
        send_frame(make_response(mrc_pkg::FC_READ_INPUT, 16'd30));
        send_frame(make_response(mrc_pkg::FC_READ_INPUT, 16'd30));
    endtask

    task automatic test_random_traffic();
        int          start_count;
        logic [7:0]  fc;
        logic [15:0] qty;
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_gap_pct = 53; rx_stall_pct = 0;  end
                2: begin tx_gap_pct = 0;  rx_stall_pct = 53; end
                default: begin tx_gap_pct = 29; rx_stall_pct = 29; end
            endcase
            for (int s = 0; s < 3; s++) begin
                fc = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                 : fc_menu[$urandom_range(0, 13)];
                case (fc)
                    mrc_pkg::FC_READ_COILS, mrc_pkg::FC_READ_DISCRETE:
                        qty = 16'($urandom_range(0, 100));
                    mrc_pkg::FC_READ_HOLDING, mrc_pkg::FC_READ_INPUT,
                    mrc_pkg::FC_WRITE_READ_REGS:
                        qty = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                                          : 16'($urandom_range(0, 12));
                    default: qty = 16'($urandom_range(0, 65535));
                endcase
                set_request(fc, qty);
                start_count = bytes_accepted;
                while (bytes_accepted - start_count < SET_BYTES) send_random_frame();
            end
        end
    endtask

    // result side: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (holdoff_requests != holdoff_served) begin
            holdoff_served <= holdoff_requests;
            holdoff_left   <= HOLDOFF_CYCLES;
            res_chan.ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left   <= holdoff_left - 1;
            res_chan.ready <= 1'b0;
        end else begin
            res_chan.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_chan.valid && res_chan.ready) begin
            if (pending_frame_results.size() == 0) begin
                $error("result beat with nothing expected: kind %0d word %0d status %0d",
                       res_chan.result_kind, res_chan.word_value, res_chan.status);
                error_count++;
            end else begin
                head_result = pending_frame_results.pop_front();
                check_field("result_kind", head_result.kind, res_chan.result_kind);
                check_field("word_value", head_result.word, res_chan.word_value);
                check_field("value_count", head_result.count, res_chan.value_count);
                check_field("status", head_result.status, res_chan.status);
                check_field("exc_code", head_result.exc, res_chan.exc_code);
                check_field("crc_ok", head_result.crc_ok, res_chan.crc_ok);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((rx_chan.valid && rx_chan.ready) || (res_chan.valid && res_chan.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = mrc_pkg::REG_REQ_FUNCTION;
        i_cfg_wdata       = 16'h0000;
        rx_chan.valid     = 1'b0;
        rx_chan.rx_byte   = 8'h00;
        rx_chan.frame_end = 1'b0;
        res_chan.ready    = 1'b0;
        req_func_copy     = mrc_pkg::REQ_FUNCTION_RST;
        req_qty_copy      = 16'h0000;
        clear_frame_state();

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_frames();
        test_request_extremes();
        test_overlong_frame();
        test_output_holdoff();
        test_random_traffic();

        wait_for_idle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
hdl/mrc_pkg.sv
hdl/mrc_ifs.sv
hdl/modbus_rtu_response_checker.sv
hdl/mrc_checker.sv
tb/sv/modbus_rtu_response_checker_test.sv
